FILE: hw/rtl/rvex_pkg.sv
package rvex_pkg;

	localparam int unsigned XLEN       = 64;
	localparam int unsigned MODE_W     = 5;
	localparam int unsigned CSR_ADDR_W = 12;
	localparam int unsigned ZIMM_W     = 5;
	localparam int unsigned SHAMT_W    = 6;
	localparam int unsigned EXC_W      = 2;
	localparam logic [XLEN-1:0] LINK_OFFSET = 64'd4;

	typedef enum logic [MODE_W-1:0] {
		OP_LUI    = 5'd0,
		OP_AUIPC  = 5'd1,
		OP_JAL    = 5'd2,
		OP_JALR   = 5'd3,
		OP_ADDI   = 5'd4,
		OP_SLTI   = 5'd5,
		OP_SLTIU  = 5'd6,
		OP_XORI   = 5'd7,
		OP_ORI    = 5'd8,
		OP_ANDI   = 5'd9,
		OP_SLLI   = 5'd10,
		OP_SRLI   = 5'd11,
		OP_SRAI   = 5'd12,
		OP_ADD    = 5'd13,
		OP_SUB    = 5'd14,
		OP_SLL    = 5'd15,
		OP_SLT    = 5'd16,
		OP_SLTU   = 5'd17,
		OP_XOR    = 5'd18,
		OP_SRL    = 5'd19,
		OP_SRA    = 5'd20,
		OP_OR     = 5'd21,
		OP_AND    = 5'd22,
		OP_ECALL  = 5'd23,
		OP_EBREAK = 5'd24,
		OP_CSRRW  = 5'd25,
		OP_CSRRS  = 5'd26,
		OP_CSRRC  = 5'd27,
		OP_CSRRWI = 5'd28,
		OP_CSRRSI = 5'd29,
		OP_CSRRCI = 5'd30,
		OP_NONE   = 5'd31
	} mode_t;

	typedef enum logic [EXC_W-1:0] {
		EXC_NONE  = 2'd0,
		EXC_ECALL = 2'd1,
		EXC_BREAK = 2'd2
	} exc_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [XLEN-1:0]   pc;
		logic [XLEN-1:0]   imm;
		logic [XLEN-1:0]   src0;
		logic [XLEN-1:0]   src1;
		logic [XLEN-1:0]   csr_old;
		logic [ZIMM_W-1:0] zimm;
	} uop_t;

	typedef struct packed {
		logic [XLEN-1:0]       result;
		logic                  csr_write_enable;
		logic [CSR_ADDR_W-1:0] csr_address;
		logic [XLEN-1:0]       csr_write_data;
		logic [EXC_W-1:0]      exception_kind;
	} res_t;

endpackage

FILE: hw/rtl/rvex_alu.sv
module rvex_alu
	import rvex_pkg::*;
(
	input  uop_t uop,
	output res_t res
);

	logic [XLEN-1:0]    a;
	logic [XLEN-1:0]    b;
	logic [XLEN-1:0]    imm;
	logic [XLEN-1:0]    zi;
	logic [SHAMT_W-1:0] shi;
	logic [SHAMT_W-1:0] shr;

	assign a   = uop.src0;
	assign b   = uop.src1;
	assign imm = uop.imm;
	assign zi  = {{(XLEN-ZIMM_W){1'b0}}, uop.zimm};
	assign shi = imm[SHAMT_W-1:0];
	assign shr = b[SHAMT_W-1:0];

	always_comb begin
		res = '0;
		case (mode_t'(uop.mode))
			OP_LUI:    res.result = imm;
			OP_AUIPC:  res.result = uop.pc + imm;
			OP_JAL,
			OP_JALR:   res.result = uop.pc + LINK_OFFSET;
			OP_ADDI:   res.result = a + imm;
			OP_SLTI:   res.result = {{(XLEN-1){1'b0}}, $signed(a) < $signed(imm)};
			OP_SLTIU:  res.result = {{(XLEN-1){1'b0}}, a < imm};
			OP_XORI:   res.result = a ^ imm;
			OP_ORI:    res.result = a | imm;
			OP_ANDI:   res.result = a & imm;
			OP_SLLI:   res.result = a << shi;
			OP_SRLI:   res.result = a >> shi;
			OP_SRAI:   res.result = $unsigned($signed(a) >>> shi);
			OP_ADD:    res.result = a + b;
			OP_SUB:    res.result = a - b;
			OP_SLL:    res.result = a << shr;
			OP_SLT:    res.result = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
			OP_SLTU:   res.result = {{(XLEN-1){1'b0}}, a < b};
			OP_XOR:    res.result = a ^ b;
			OP_SRL:    res.result = a >> shr;
			OP_SRA:    res.result = $unsigned($signed(a) >>> shr);
			OP_OR:     res.result = a | b;
			OP_AND:    res.result = a & b;
			OP_ECALL: begin
				res.result         = uop.csr_old;
				res.csr_address    = imm[CSR_ADDR_W-1:0];
				res.exception_kind = EXC_ECALL;
			end
			OP_EBREAK: begin
				res.result         = uop.csr_old;
				res.csr_address    = imm[CSR_ADDR_W-1:0];
				res.exception_kind = EXC_BREAK;
			end
			OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI: begin
				res.result           = uop.csr_old;
				res.csr_address      = imm[CSR_ADDR_W-1:0];
				res.csr_write_enable = 1'b1;
				case (mode_t'(uop.mode))
					OP_CSRRW:  res.csr_write_data = a;
					OP_CSRRS:  res.csr_write_data = uop.csr_old | a;
					OP_CSRRC:  res.csr_write_data = uop.csr_old & ~a;
					OP_CSRRWI: res.csr_write_data = zi;
					OP_CSRRSI: res.csr_write_data = uop.csr_old | zi;
					default:   res.csr_write_data = uop.csr_old & ~zi;
				endcase
			end
			default: res = '0;
		endcase
	end

endmodule

FILE: hw/rtl/rv64i_alu_csr_execute_unit.sv
// rv64i integer execute unit with csr read-modify-write
// input channel: in_valid / in_ready carry one micro-op per transaction
// (mode, pc, imm, src0, src1, csr_old, zimm)
// output channel: out_valid / out_ready carry one result per transaction
// (result, csr_write_enable, csr_address, csr_write_data, exception_kind)
// every micro-op gives exactly one result, in order
// the micro-op is captured in the input register while the alu works on it,
// and its result is then registered in the result register that drives out_valid
// throughput: one micro-op per cycle while out_ready is held high
// when the receiver stalls the result register holds its transaction and
// the input register fills; in_ready drops once both are occupied
// reset (arst_n low) empties both stages; no state survives a transaction,
// the register file and csr storage are outside this block
module rv64i_alu_csr_execute_unit
	import rvex_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [MODE_W-1:0]     mode,
	input  logic [XLEN-1:0]       pc,
	input  logic [XLEN-1:0]       imm,
	input  logic [XLEN-1:0]       src0,
	input  logic [XLEN-1:0]       src1,
	input  logic [XLEN-1:0]       csr_old,
	input  logic [ZIMM_W-1:0]     zimm,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [XLEN-1:0]       result,
	output logic                  csr_write_enable,
	output logic [CSR_ADDR_W-1:0] csr_address,
	output logic [XLEN-1:0]       csr_write_data,
	output logic [EXC_W-1:0]      exception_kind
);

	logic valid_s1;
	logic valid_s2;
	uop_t uop_s1;
	res_t res_d;
	res_t res_s2;
	logic s2_ready;

	assign s2_ready = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			uop_s1 <= '{mode: mode, pc: pc, imm: imm, src0: src0, src1: src1,
			            csr_old: csr_old, zimm: zimm};
		end
	end

	rvex_alu u_alu (
		.uop (uop_s1),
		.res (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid        = valid_s2;
	assign result           = res_s2.result;
	assign csr_write_enable = res_s2.csr_write_enable;
	assign csr_address      = res_s2.csr_address;
	assign csr_write_data   = res_s2.csr_write_data;
	assign exception_kind   = res_s2.exception_kind;

endmodule
